// ===== hdl/hwhp_pkg.sv =====
// Shared types and constants for the HSV window histogram peak unit.
`timescale 1ns / 1ps

package hwhp_pkg;

    // Fixed field widths of the pixel and result beats
    localparam int PIX_W         = 8;
    localparam int FIELD_WIN_W   = 5;
    localparam int LINE_WIN_W    = 3;
    localparam int COUNT_FIELD_W = 22;
    localparam int IN_TDATA_W    = 24;
    localparam int OUT_TDATA_W   = 56;
    localparam int OUT_USED_W    = 2 * COUNT_FIELD_W + FIELD_WIN_W + LINE_WIN_W;

    // Configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 8;

    localparam int HUE_STEP_W  = 4;
    localparam int HUE_WIDTH_W = 7;
    localparam int SAT_STEP_W  = 6;
    localparam int SAT_WIDTH_W = 7;

    localparam logic [HUE_STEP_W-1:0]  HUE_STEP_RST          = 4'd10;
    localparam logic [HUE_WIDTH_W-1:0] HUE_WIDTH_RST         = 7'd20;
    localparam logic [PIX_W-1:0]       FIELD_SAT_FLOOR_RST   = 8'd75;
    localparam logic [PIX_W-1:0]       FIELD_VAL_CEILING_RST = 8'd200;
    localparam logic [SAT_STEP_W-1:0]  SAT_STEP_RST          = 6'd12;
    localparam logic [SAT_WIDTH_W-1:0] SAT_WIDTH_RST         = 7'd25;
    localparam logic [PIX_W-1:0]       LINE_VAL_FLOOR_RST    = 8'd25;

    // Default sizes
    localparam int NUM_HUE_WINDOWS_DEF = 20;
    localparam int NUM_SAT_WINDOWS_DEF = 6;
    localparam int COUNT_BITS_DEF      = 22;
    localparam int QUEUE_DEPTH         = 4;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_HUE_STEP          = 3'd0,
        CFG_HUE_WIDTH         = 3'd1,
        CFG_FIELD_SAT_FLOOR   = 3'd2,
        CFG_FIELD_VAL_CEILING = 3'd3,
        CFG_SAT_STEP          = 3'd4,
        CFG_SAT_WIDTH         = 3'd5,
        CFG_LINE_VAL_FLOOR    = 3'd6
    } t_cfg_index;

    typedef enum logic [2:0] {
        S_COUNT = 3'b001,
        S_SCAN  = 3'b010,
        S_EMIT  = 3'b100
    } t_back_state;

endpackage

// ===== hdl/hwhp_front.sv =====
// Front end: configuration registers and per-window classification of each pixel.
`timescale 1ns / 1ps

module hwhp_front
    import hwhp_pkg::*;
#(
    parameter int NUM_HUE_WINDOWS = NUM_HUE_WINDOWS_DEF,
    parameter int NUM_SAT_WINDOWS = NUM_SAT_WINDOWS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    input  logic [CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data,
    input  logic [PIX_W-1:0]           i_hue,
    input  logic [PIX_W-1:0]           i_sat,
    input  logic [PIX_W-1:0]           i_val,
    output logic [NUM_HUE_WINDOWS-1:0] o_hue_hit,
    output logic [NUM_SAT_WINDOWS-1:0] o_sat_hit
);

    localparam int HUE_LANE_W = $clog2(NUM_HUE_WINDOWS + 1);
    localparam int SAT_LANE_W = $clog2(NUM_SAT_WINDOWS + 1);
    localparam int HUE_CMP_W  = HUE_STEP_W + HUE_LANE_W + PIX_W;
    localparam int SAT_CMP_W  = SAT_STEP_W + SAT_LANE_W + PIX_W;

    logic [HUE_STEP_W-1:0]  r_hue_step;
    logic [HUE_WIDTH_W-1:0] r_hue_width;
    logic [PIX_W-1:0]       r_field_sat_floor;
    logic [PIX_W-1:0]       r_field_val_ceiling;
    logic [SAT_STEP_W-1:0]  r_sat_step;
    logic [SAT_WIDTH_W-1:0] r_sat_width;
    logic [PIX_W-1:0]       r_line_val_floor;

    logic w_field_gate;
    logic w_line_gate;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hue_step          <= HUE_STEP_RST;
            r_hue_width         <= HUE_WIDTH_RST;
            r_field_sat_floor   <= FIELD_SAT_FLOOR_RST;
            r_field_val_ceiling <= FIELD_VAL_CEILING_RST;
            r_sat_step          <= SAT_STEP_RST;
            r_sat_width         <= SAT_WIDTH_RST;
            r_line_val_floor    <= LINE_VAL_FLOOR_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_HUE_STEP:          r_hue_step          <= i_cfg_data[HUE_STEP_W-1:0];
                CFG_HUE_WIDTH:         r_hue_width         <= i_cfg_data[HUE_WIDTH_W-1:0];
                CFG_FIELD_SAT_FLOOR:   r_field_sat_floor   <= i_cfg_data;
                CFG_FIELD_VAL_CEILING: r_field_val_ceiling <= i_cfg_data;
                CFG_SAT_STEP:          r_sat_step          <= i_cfg_data[SAT_STEP_W-1:0];
                CFG_SAT_WIDTH:         r_sat_width         <= i_cfg_data[SAT_WIDTH_W-1:0];
                CFG_LINE_VAL_FLOOR:    r_line_val_floor    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_field_gate = (i_sat >= r_field_sat_floor) && (i_val <= r_field_val_ceiling);
    assign w_line_gate  = (i_val >= r_line_val_floor);

    // Each window start is a constant lane number times the step; bounds never wrap
    for (genvar gi = 0; gi < NUM_HUE_WINDOWS; gi++) begin : g_hue
        localparam logic [HUE_CMP_W-1:0] LANE = HUE_CMP_W'(gi);
        logic [HUE_CMP_W-1:0] w_start;
        logic [HUE_CMP_W-1:0] w_pix;
        logic [HUE_CMP_W-1:0] w_diff;
        assign w_start = HUE_CMP_W'(r_hue_step) * LANE;
        assign w_pix   = HUE_CMP_W'(i_hue);
        assign w_diff  = w_pix - w_start;
        assign o_hue_hit[gi] = w_field_gate && (w_pix >= w_start)
                               && (w_diff < HUE_CMP_W'(r_hue_width));
    end

    for (genvar gj = 0; gj < NUM_SAT_WINDOWS; gj++) begin : g_sat
        localparam logic [SAT_CMP_W-1:0] LANE = SAT_CMP_W'(gj);
        logic [SAT_CMP_W-1:0] w_start;
        logic [SAT_CMP_W-1:0] w_pix;
        logic [SAT_CMP_W-1:0] w_diff;
        assign w_start = SAT_CMP_W'(r_sat_step) * LANE;
        assign w_pix   = SAT_CMP_W'(i_sat);
        assign w_diff  = w_pix - w_start;
        assign o_sat_hit[gj] = w_line_gate && (w_pix >= w_start)
                               && (w_diff < SAT_CMP_W'(r_sat_width));
    end

endmodule

// ===== hdl/hwhp_queue.sv =====
// Short queue of classified pixels between the front and back ends.
`timescale 1ns / 1ps

module hwhp_queue
    import hwhp_pkg::*;
#(
    parameter int WIDTH = 27,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_wr_data,
    output logic             o_full,
    input  logic             i_rd,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;

    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_valid   = (r_count != '0);
    assign o_rd_data = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_wr) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_rd) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_wr && !i_rd) begin
            n_count = r_count + 1'b1;
        end else if (i_rd && !i_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    property p_no_overflow;
        @(posedge i_clk) disable iff (!i_rst_n) (i_wr && o_full) |-> i_rd;
    endproperty
    a_no_overflow: assert property (p_no_overflow) else $error("queue written while full");

    property p_no_underflow;
        @(posedge i_clk) disable iff (!i_rst_n) i_rd |-> o_valid;
    endproperty
    a_no_underflow: assert property (p_no_underflow) else $error("queue read while empty");

endmodule

// ===== hdl/hwhp_back.sv =====
// Back end: saturating window counters, frame-end peak scan and result register.
`timescale 1ns / 1ps

module hwhp_back
    import hwhp_pkg::*;
#(
    parameter int NUM_HUE_WINDOWS = NUM_HUE_WINDOWS_DEF,
    parameter int NUM_SAT_WINDOWS = NUM_SAT_WINDOWS_DEF,
    parameter int COUNT_BITS      = COUNT_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_q_valid,
    input  logic [NUM_HUE_WINDOWS-1:0] i_hue_hit,
    input  logic [NUM_SAT_WINDOWS-1:0] i_sat_hit,
    input  logic                       i_last,
    output logic                       o_q_rd,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [FIELD_WIN_W-1:0]     o_field_window,
    output logic [COUNT_FIELD_W-1:0]   o_field_count,
    output logic [LINE_WIN_W-1:0]      o_line_window,
    output logic [COUNT_FIELD_W-1:0]   o_line_count
);

    localparam int SCAN_N = (NUM_HUE_WINDOWS > NUM_SAT_WINDOWS) ? NUM_HUE_WINDOWS
                                                                : NUM_SAT_WINDOWS;
    localparam int SCAN_W = (SCAN_N > 1) ? $clog2(SCAN_N) : 1;
    localparam int HIDX_W = (NUM_HUE_WINDOWS > 1) ? $clog2(NUM_HUE_WINDOWS) : 1;
    localparam int SIDX_W = (NUM_SAT_WINDOWS > 1) ? $clog2(NUM_SAT_WINDOWS) : 1;

    t_back_state r_state, n_state;

    logic [COUNT_BITS-1:0] r_hcnt [NUM_HUE_WINDOWS];
    logic [COUNT_BITS-1:0] r_scnt [NUM_SAT_WINDOWS];

    logic [SCAN_W-1:0]     r_scan, n_scan;
    logic [COUNT_BITS-1:0] r_best_h, n_best_h;
    logic [HIDX_W-1:0]     r_best_h_idx, n_best_h_idx;
    logic [COUNT_BITS-1:0] r_best_s, n_best_s;
    logic [SIDX_W-1:0]     r_best_s_idx, n_best_s_idx;

    logic                     r_out_valid;
    logic [FIELD_WIN_W-1:0]   r_field_window;
    logic [COUNT_FIELD_W-1:0] r_field_count;
    logic [LINE_WIN_W-1:0]    r_line_window;
    logic [COUNT_FIELD_W-1:0] r_line_count;

    logic                  w_pop;
    logic                  w_load;
    logic                  w_h_in_range;
    logic                  w_s_in_range;
    logic [COUNT_BITS-1:0] w_h_cur;
    logic [COUNT_BITS-1:0] w_s_cur;

    assign w_pop  = (r_state == S_COUNT) && i_q_valid;
    assign w_load = (r_state == S_EMIT) && (!r_out_valid || i_out_ready);
    assign o_q_rd = w_pop;

    assign w_h_in_range = ({1'b0, r_scan} < (SCAN_W + 1)'(NUM_HUE_WINDOWS));
    assign w_s_in_range = ({1'b0, r_scan} < (SCAN_W + 1)'(NUM_SAT_WINDOWS));
    assign w_h_cur = r_hcnt[r_scan[HIDX_W-1:0]];
    assign w_s_cur = r_scnt[r_scan[SIDX_W-1:0]];

    always_comb begin
        n_state      = r_state;
        n_scan       = r_scan;
        n_best_h     = r_best_h;
        n_best_h_idx = r_best_h_idx;
        n_best_s     = r_best_s;
        n_best_s_idx = r_best_s_idx;
        case (r_state)
            S_COUNT: begin
                if (w_pop && i_last) begin
                    n_state      = S_SCAN;
                    n_scan       = '0;
                    n_best_h     = '0;
                    n_best_h_idx = '0;
                    n_best_s     = '0;
                    n_best_s_idx = '0;
                end
            end
            S_SCAN: begin
                // strict compare keeps the first window among equal counts
                if (w_h_in_range && (w_h_cur > r_best_h)) begin
                    n_best_h     = w_h_cur;
                    n_best_h_idx = r_scan[HIDX_W-1:0];
                end
                if (w_s_in_range && (w_s_cur > r_best_s)) begin
                    n_best_s     = w_s_cur;
                    n_best_s_idx = r_scan[SIDX_W-1:0];
                end
                if (r_scan == SCAN_W'(SCAN_N - 1)) begin
                    n_state = S_EMIT;
                end else begin
                    n_scan = r_scan + 1'b1;
                end
            end
            S_EMIT: begin
                if (w_load) begin
                    n_state = S_COUNT;
                end
            end
            default: n_state = S_COUNT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_COUNT;
            r_scan  <= '0;
        end else begin
            r_state <= n_state;
            r_scan  <= n_scan;
        end
    end

    always_ff @(posedge i_clk) begin
        r_best_h     <= n_best_h;
        r_best_h_idx <= n_best_h_idx;
        r_best_s     <= n_best_s;
        r_best_s_idx <= n_best_s_idx;
    end

    // Counters: bump on hit and hold at full scale, clear on reset and when the result is loaded
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NUM_HUE_WINDOWS; i++) begin
            if (!i_rst_n || w_load) begin
                r_hcnt[i] <= '0;
            end else if (w_pop && i_hue_hit[i] && (r_hcnt[i] != '1)) begin
                r_hcnt[i] <= r_hcnt[i] + 1'b1;
            end
        end
        for (int j = 0; j < NUM_SAT_WINDOWS; j++) begin
            if (!i_rst_n || w_load) begin
                r_scnt[j] <= '0;
            end else if (w_pop && i_sat_hit[j] && (r_scnt[j] != '1)) begin
                r_scnt[j] <= r_scnt[j] + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_field_window <= FIELD_WIN_W'(r_best_h_idx);
            r_field_count  <= COUNT_FIELD_W'(r_best_h);
            r_line_window  <= LINE_WIN_W'(r_best_s_idx);
            r_line_count   <= COUNT_FIELD_W'(r_best_s);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_field_window = r_field_window;
    assign o_field_count  = r_field_count;
    assign o_line_window  = r_line_window;
    assign o_line_count   = r_line_count;

    property p_cleared_after_load;
        @(posedge i_clk) disable iff (!i_rst_n)
            w_load |=> (r_hcnt[0] == '0) && (r_scnt[0] == '0);
    endproperty
    a_cleared_after_load: assert property (p_cleared_after_load)
        else $error("counters not cleared after frame result");

    property p_result_from_emit;
        @(posedge i_clk) disable iff (!i_rst_n)
            $rose(r_out_valid) |-> $past(r_state == S_EMIT);
    endproperty
    a_result_from_emit: assert property (p_result_from_emit)
        else $error("result raised outside of emit");

    property p_no_pop_while_scanning;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_state == S_SCAN || r_state == S_EMIT) |-> !o_q_rd;
    endproperty
    a_no_pop_while_scanning: assert property (p_no_pop_while_scanning)
        else $error("queue popped during peak scan");

    property p_scan_enters_after_last;
        @(posedge i_clk) disable iff (!i_rst_n)
            $rose(r_state == S_SCAN) |-> $past(w_pop && i_last);
    endproperty
    a_scan_enters_after_last: assert property (p_scan_enters_after_last)
        else $error("peak scan started without a last pixel");

endmodule

// ===== hdl/hsv_window_histogram_peak_unit.sv =====
// Top level of the HSV window histogram peak unit.
//
//  channel  | direction | handshake                        | payload
//  ---------+-----------+----------------------------------+----------------------------------
//  s_axis   | in        | s_axis_tvalid / s_axis_tready    | tdata hue,sat,val; tlast frame end
//  m_axis   | out       | m_axis_tvalid / m_axis_tready    | tdata field/line window and count
//  cfg      | in        | i_cfg_valid / o_cfg_ready        | i_cfg_index, i_cfg_data
//
// Pixels are taken one per clock while the four-beat pixel queue has room.
// After the last pixel of a frame the back end scans every window and then loads the result;
// meanwhile the queue takes up to four more pixels, then tready drops.
// Reset (synchronous, active low) loads register defaults and zeroes all counters.
// A stalled result beat holds in the output register and the back end waits to load the
// next one; pixels back up in the queue until it is full.
`timescale 1ns / 1ps

module hsv_window_histogram_peak_unit
    import hwhp_pkg::*;
#(
    parameter int NUM_HUE_WINDOWS = NUM_HUE_WINDOWS_DEF,
    parameter int NUM_SAT_WINDOWS = NUM_SAT_WINDOWS_DEF,
    parameter int COUNT_BITS      = COUNT_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // hue[7:0], sat[15:8], val[23:16]
    input  logic                   s_axis_tlast,   // last_pixel
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // field_window[4:0], field_count[26:5], line_window[29:27], line_count[51:30]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int ENTRY_W = NUM_HUE_WINDOWS + NUM_SAT_WINDOWS + 1;

    logic [NUM_HUE_WINDOWS-1:0] w_hue_hit;
    logic [NUM_SAT_WINDOWS-1:0] w_sat_hit;
    logic                       w_q_full;
    logic                       w_q_valid;
    logic                       w_q_rd;
    logic                       w_in_beat;
    logic [ENTRY_W-1:0]         w_q_wr_data;
    logic [ENTRY_W-1:0]         w_q_rd_data;
    logic [FIELD_WIN_W-1:0]     w_field_window;
    logic [COUNT_FIELD_W-1:0]   w_field_count;
    logic [LINE_WIN_W-1:0]      w_line_window;
    logic [COUNT_FIELD_W-1:0]   w_line_count;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !w_q_full;
    assign w_in_beat     = s_axis_tvalid && !w_q_full;

    hwhp_front #(
        .NUM_HUE_WINDOWS (NUM_HUE_WINDOWS),
        .NUM_SAT_WINDOWS (NUM_SAT_WINDOWS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_hue       (s_axis_tdata[PIX_W-1:0]),
        .i_sat       (s_axis_tdata[2*PIX_W-1:PIX_W]),
        .i_val       (s_axis_tdata[3*PIX_W-1:2*PIX_W]),
        .o_hue_hit   (w_hue_hit),
        .o_sat_hit   (w_sat_hit)
    );

    assign w_q_wr_data = {s_axis_tlast, w_sat_hit, w_hue_hit};

    hwhp_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (w_in_beat),
        .i_wr_data (w_q_wr_data),
        .o_full    (w_q_full),
        .i_rd      (w_q_rd),
        .o_valid   (w_q_valid),
        .o_rd_data (w_q_rd_data)
    );

    hwhp_back #(
        .NUM_HUE_WINDOWS (NUM_HUE_WINDOWS),
        .NUM_SAT_WINDOWS (NUM_SAT_WINDOWS),
        .COUNT_BITS      (COUNT_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (w_q_valid),
        .i_hue_hit      (w_q_rd_data[NUM_HUE_WINDOWS-1:0]),
        .i_sat_hit      (w_q_rd_data[NUM_HUE_WINDOWS+NUM_SAT_WINDOWS-1:NUM_HUE_WINDOWS]),
        .i_last         (w_q_rd_data[ENTRY_W-1]),
        .o_q_rd         (w_q_rd),
        .o_out_valid    (m_axis_tvalid),
        .i_out_ready    (m_axis_tready),
        .o_field_window (w_field_window),
        .o_field_count  (w_field_count),
        .o_line_window  (w_line_window),
        .o_line_count   (w_line_count)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W - OUT_USED_W){1'b0}},
                           w_line_count, w_line_window, w_field_count, w_field_window};

endmodule

// ===== tb/sv/tb_hsv_window_histogram_peak_unit.sv =====
// Self-checking testbench for the HSV window histogram peak unit.
`timescale 1ns / 1ps

module tb_hsv_window_histogram_peak_unit;
    import hwhp_pkg::*;

    localparam int NUM_HUE = NUM_HUE_WINDOWS_DEF;
    localparam int NUM_SAT = NUM_SAT_WINDOWS_DEF;
    localparam int FC_LSB  = FIELD_WIN_W;
    localparam int LW_LSB  = FC_LSB + COUNT_FIELD_W;
    localparam int LC_LSB  = LW_LSB + LINE_WIN_W;
    localparam int DRAIN_CYCLES = 64;
    localparam int HOLD_CYCLES  = 400;
    localparam int TIMEOUT_NS   = 2_000_000;
    // No register lives at this index; writes to it must be dropped
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 3'd7;

    typedef logic [COUNT_FIELD_W-1:0] t_count;

    typedef struct {
        logic [PIX_W-1:0] hue;
        logic [PIX_W-1:0] sat;
        logic [PIX_W-1:0] val;
        logic             last;
    } t_pixel;

    typedef struct packed {
        logic [FIELD_WIN_W-1:0]   field_window;
        t_count                   field_count;
        logic [LINE_WIN_W-1:0]    line_window;
        t_count                   line_count;
    } t_peak;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // hue[7:0], sat[15:8], val[23:16]
    logic                   s_axis_tlast = 1'b0; // last_pixel
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // field_window[4:0], field_count[26:5], line_window[29:27], line_count[51:30]
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    hsv_window_histogram_peak_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Shadow registers and window counters
    logic [HUE_STEP_W-1:0]  hue_step       = HUE_STEP_RST;
    logic [HUE_WIDTH_W-1:0] hue_width      = HUE_WIDTH_RST;
    logic [PIX_W-1:0]       fsat_floor     = FIELD_SAT_FLOOR_RST;
    logic [PIX_W-1:0]       fval_ceiling   = FIELD_VAL_CEILING_RST;
    logic [SAT_STEP_W-1:0]  sat_step       = SAT_STEP_RST;
    logic [SAT_WIDTH_W-1:0] sat_width      = SAT_WIDTH_RST;
    logic [PIX_W-1:0]       lval_floor     = LINE_VAL_FLOOR_RST;
    t_count                 hue_hist [NUM_HUE];
    t_count                 sat_hist [NUM_SAT];

    t_pixel pixel_q[$];
    t_peak  peak_q[$];
    t_pixel next_px;

    int mismatch_cnt = 0;
    int peaks_seen   = 0;
    int burst_left   = 1;
    int gap_left     = 0;
    int hold_left    = 0;
    int holds_done   = 0;
    logic [7:0] rx_tick = '0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("status: fail");
        $finish;
    end

    function automatic void shadow_reg(input logic [CFG_INDEX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_HUE_STEP:          hue_step     = data[HUE_STEP_W-1:0];
            CFG_HUE_WIDTH:         hue_width    = data[HUE_WIDTH_W-1:0];
            CFG_FIELD_SAT_FLOOR:   fsat_floor   = data;
            CFG_FIELD_VAL_CEILING: fval_ceiling = data;
            CFG_SAT_STEP:          sat_step     = data[SAT_STEP_W-1:0];
            CFG_SAT_WIDTH:         sat_width    = data[SAT_WIDTH_W-1:0];
            CFG_LINE_VAL_FLOOR:    lval_floor   = data;
            default: ;
        endcase
    endfunction

    // Count one accepted pixel; on frame end queue the peak and clear the histograms
    function automatic void tally_pixel(input logic [IN_TDATA_W-1:0] beat, input logic last);
        int    hue;
        int    sat;
        int    val;
        int    start;
        t_peak peak;
        hue = int'(beat[7:0]);
        sat = int'(beat[15:8]);
        val = int'(beat[23:16]);
        if (sat >= int'(fsat_floor) && val <= int'(fval_ceiling)) begin
            for (int i = 0; i < NUM_HUE; i++) begin
                start = int'(hue_step) * i;
                if (hue >= start && hue - start < int'(hue_width) && hue_hist[i] != '1)
                    hue_hist[i]++;
            end
        end
        if (val >= int'(lval_floor)) begin
            for (int j = 0; j < NUM_SAT; j++) begin
                start = int'(sat_step) * j;
                if (sat >= start && sat - start < int'(sat_width) && sat_hist[j] != '1)
                    sat_hist[j]++;
            end
        end
        if (last) begin
            peak = '0;
            // Strict compare keeps the lowest index on a tie
            for (int i = 0; i < NUM_HUE; i++) begin
                if (hue_hist[i] > peak.field_count) begin
                    peak.field_count  = hue_hist[i];
                    peak.field_window = FIELD_WIN_W'(i);
                end
                hue_hist[i] = '0;
            end
            for (int j = 0; j < NUM_SAT; j++) begin
                if (sat_hist[j] > peak.line_count) begin
                    peak.line_count  = sat_hist[j];
                    peak.line_window = LINE_WIN_W'(j);
                end
                sat_hist[j] = '0;
            end
            peak_q.push_back(peak);
        end
    endfunction

    function automatic void flag_mismatch(input string what, input longint want,
                                          input longint got);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, want, got);
    endfunction

    function automatic void check_peak(input logic [OUT_TDATA_W-1:0] beat);
        t_peak want;
        if (peak_q.size() == 0) begin
            flag_mismatch("result with none pending, tdata", 0, beat);
            return;
        end
        want = peak_q.pop_front();
        if (beat[FIELD_WIN_W-1:0] !== want.field_window)
            flag_mismatch("field_window", want.field_window, beat[FIELD_WIN_W-1:0]);
        if (beat[FC_LSB +: COUNT_FIELD_W] !== want.field_count)
            flag_mismatch("field_count", want.field_count, beat[FC_LSB +: COUNT_FIELD_W]);
        if (beat[LW_LSB +: LINE_WIN_W] !== want.line_window)
            flag_mismatch("line_window", want.line_window, beat[LW_LSB +: LINE_WIN_W]);
        if (beat[LC_LSB +: COUNT_FIELD_W] !== want.line_count)
            flag_mismatch("line_count", want.line_count, beat[LC_LSB +: COUNT_FIELD_W]);
        if (beat[OUT_TDATA_W-1:OUT_USED_W] !== '0)
            flag_mismatch("tdata pad", 0, beat[OUT_TDATA_W-1:OUT_USED_W]);
    endfunction

    // Pixel driver: bursts of random length separated by random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            burst_left    <= 1;
            gap_left      <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                tally_pixel(s_axis_tdata, s_axis_tlast);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left != 0) begin
                    gap_left      <= gap_left - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (pixel_q.size() != 0) begin
                    next_px = pixel_q.pop_front();
                    s_axis_tdata  <= {next_px.val, next_px.sat, next_px.hue};
                    s_axis_tlast  <= next_px.last;
                    s_axis_tvalid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(60, 120)
                                                                   : $urandom_range(1, 24);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long result hold-off so the pixel queue backs up and drops tready
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left  <= 0;
            holds_done <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (holds_done < 2 && peaks_seen >= 30 + 50 * holds_done) begin
            hold_left  <= HOLD_CYCLES;
            holds_done <= holds_done + 1;
        end
    end

    // Result monitor and receiver stall pattern
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_tick       <= '0;
            peaks_seen    <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                check_peak(m_axis_tdata);
                peaks_seen <= peaks_seen + 1;
            end
            rx_tick <= rx_tick + 1'b1;
            if (hold_left != 0) begin
                m_axis_tready <= 1'b0;
            end else begin
                case (rx_tick[7:6])
                    2'd0:    m_axis_tready <= 1'b1;
                    2'd1:    m_axis_tready <= 1'($urandom_range(0, 1));
                    2'd2:    m_axis_tready <= (rx_tick[1:0] == 2'd0);
                    default: m_axis_tready <= ($urandom_range(0, 4) != 0);
                endcase
            end
        end
    end

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        shadow_reg(idx, data);
    endtask

    task automatic program_regs(input logic [7:0] hs, input logic [7:0] hw,
                                input logic [7:0] sf, input logic [7:0] vc,
                                input logic [7:0] ss, input logic [7:0] sw,
                                input logic [7:0] lf);
        write_reg(CFG_HUE_STEP, hs);
        write_reg(CFG_HUE_WIDTH, hw);
        write_reg(CFG_FIELD_SAT_FLOOR, sf);
        write_reg(CFG_FIELD_VAL_CEILING, vc);
        write_reg(CFG_SAT_STEP, ss);
        write_reg(CFG_SAT_WIDTH, sw);
        write_reg(CFG_LINE_VAL_FLOOR, lf);
    endtask

    // Wait until every pixel is in and every peak is out, then let the back end settle
    task automatic settle();
        while (pixel_q.size() != 0 || s_axis_tvalid || peak_q.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic push_pixel(input int hue, input int sat, input int val, input bit last);
        t_pixel px;
        px.hue  = PIX_W'(hue);
        px.sat  = PIX_W'(sat);
        px.val  = PIX_W'(val);
        px.last = last;
        pixel_q.push_back(px);
    endtask

    // Mostly clustered frames so windows compete; the rest is uniform noise
    task automatic push_frame(input int len);
        bit         clustered;
        logic [7:0] hue_c;
        logic [7:0] sat_c;
        clustered = ($urandom_range(0, 3) != 0);
        hue_c = 8'($urandom);
        sat_c = 8'($urandom);
        for (int k = 0; k < len; k++) begin
            if (clustered && $urandom_range(0, 7) != 0)
                push_pixel(8'(hue_c + $urandom_range(0, 15)), 8'(sat_c + $urandom_range(0, 31)),
                           $urandom_range(0, 255), k == len - 1);
            else
                push_pixel($urandom_range(0, 255), $urandom_range(0, 255),
                           $urandom_range(0, 255), k == len - 1);
        end
    endtask

    task automatic run_frames(input int budget);
        int r;
        int len;
        while (budget > 0) begin
            r = $urandom_range(0, 19);
            if (r < 15)
                len = $urandom_range(1, 16);
            else if (r < 19)
                len = $urandom_range(17, 60);
            else
                len = $urandom_range(150, 260);
            push_frame(len);
            budget -= len;
        end
        settle();
    endtask

    initial begin
        for (int i = 0; i < NUM_HUE; i++) hue_hist[i] = '0;
        for (int j = 0; j < NUM_SAT; j++) sat_hist[j] = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed frames on reset settings
        push_pixel(0, 0, 0, 1);           // nothing counts: all-zero result
        push_pixel(255, 255, 255, 0);     // above every window, val over ceiling
        push_pixel(0, 75, 200, 0);        // exact floor and ceiling
        push_pixel(9, 74, 201, 0);
        push_pixel(10, 76, 199, 0);
        push_pixel(25, 255, 24, 0);       // just under the line floor
        push_pixel(209, 128, 25, 0);      // top of the last hue window
        push_pixel(210, 128, 100, 0);     // just past it
        push_pixel(255, 0, 0, 1);
        push_pixel(15, 100, 100, 0);      // tie across hue windows
        push_pixel(35, 100, 100, 1);
        push_pixel(128, 60, 128, 0);
        push_pixel(127, 36, 30, 0);
        push_pixel(129, 84, 255, 1);
        push_pixel(255, 255, 255, 1);
        settle();
        run_frames(200);

        // Everything zero: no window can match; the spare index is dropped
        program_regs(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        write_reg(CFG_SPARE, 8'hA5);
        run_frames(100);

        // All ones: masked steps and widths, windows run past 255
        program_regs(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        run_frames(150);

        // Zero step: all windows overlap at 0
        program_regs(8'd0, 8'd64, 8'd0, 8'd255, 8'd0, 8'd64, 8'd0);
        run_frames(150);

        for (int p = 0; p < 6; p++) begin
            if (p == 5)
                program_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                             8'($urandom), 8'($urandom), 8'($urandom));
            else
                program_regs(8'($urandom_range(1, 12)), 8'($urandom_range(1, 64)),
                             8'($urandom_range(0, 160)), 8'($urandom_range(100, 255)),
                             8'($urandom_range(1, 42)), 8'($urandom_range(1, 64)),
                             8'($urandom_range(0, 160)));
            run_frames(150);
        end

        if (mismatch_cnt == 0 && peak_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== hsv_window_histogram_peak_unit.f =====
hdl/hwhp_pkg.sv
hdl/hwhp_front.sv
hdl/hwhp_queue.sv
hdl/hwhp_back.sv
hdl/hsv_window_histogram_peak_unit.sv
tb/sv/tb_hsv_window_histogram_peak_unit.sv
